FILE: sv/bmpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpm_pkg
// Types and constants shared by the banked memory page mapper files.
// ----------------------------------------------------------------------------
package bmpm_pkg;

    localparam int CPU_ADDR_W  = 16;
    localparam int PORT_W      = 8;
    localparam int DISK_W      = 9;
    localparam int OFFSET_W    = 14;
    localparam int PAGE_W      = 9;
    localparam int PHYS_ADDR_W = PAGE_W + OFFSET_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 2;

    typedef enum logic [1:0] {
        MODEL_48K     = 2'd0,
        MODEL_128K    = 2'd1,
        MODEL_1024K   = 2'd2,
        MODEL_SERVICE = 2'd3
    } model_t;

    typedef enum logic [1:0] {
        DISK_NONE = 2'd0,
        DISK_DOS  = 2'd1,
        DISK_SD   = 2'd2,
        DISK_SRAM = 2'd3
    } disk_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DISK  = 1'b1;

    // Address windows (cpu_address[15:14])
    localparam logic [1:0] WIN_ROM   = 2'b00;
    localparam logic [1:0] WIN_FIX5  = 2'b01;
    localparam logic [1:0] WIN_FIX2  = 2'b10;
    localparam logic [1:0] WIN_TOP   = 2'b11;

    // Page numbers
    localparam logic [PAGE_W-1:0] PAGE_ROM_BASE = 9'h100;
    localparam logic [PAGE_W-1:0] PAGE_SERVICE  = 9'h102;
    localparam logic [PAGE_W-1:0] PAGE_DOS      = 9'h103;
    localparam logic [PAGE_W-1:0] PAGE_SD_BOOT  = 9'h021;
    localparam logic [PAGE_W-1:0] PAGE_FIX5     = 9'h005;
    localparam logic [PAGE_W-1:0] PAGE_FIX2     = 9'h002;
    localparam logic [PAGE_W-1:0] PAGE_RAM0     = 9'h000;

    // disk_state[8:6] pattern that maps the SD boot page
    localparam logic [2:0] DS_SD_BOOT = 3'b101;

    typedef struct packed {
        model_t model;
        disk_t  disk;
    } cfg_t;

    typedef struct packed {
        logic [CPU_ADDR_W-1:0] cpu_address;
        logic [PORT_W-1:0]     paging_port_main;
        logic [PORT_W-1:0]     paging_port_extra;
        logic                  dos_rom_active;
        logic [DISK_W-1:0]     disk_state;
    } req_t;

    typedef struct packed {
        logic [PHYS_ADDR_W-1:0] physical_address;
    } rsp_t;

endpackage
`default_nettype wire

FILE: sv/bmpm_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bmpm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/bmpm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpm_cfg_regs
// Machine model and disk interface registers behind the write port.
// ----------------------------------------------------------------------------
module bmpm_cfg_regs
    import bmpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    model_t model_reg;
    disk_t  disk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= MODEL_128K;
            disk_reg  <= DISK_NONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_MODEL: model_reg <= model_t'(cfg_wdata);
                CFG_IDX_DISK:  disk_reg  <= disk_t'(cfg_wdata);
                default:       ;
            endcase
        end
    end

    assign cfg.model = model_reg;
    assign cfg.disk  = disk_reg;

endmodule
`default_nettype wire

FILE: sv/bmpm_xlate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpm_xlate
// Page selection: turns one request into a physical address.
// ----------------------------------------------------------------------------
module bmpm_xlate
    import bmpm_pkg::*;
(
    input  wire cfg_t cfg,
    input  wire req_t req,
    output rsp_t      rsp
);

    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic [DISK_W-1:0]   ds;
    logic [PORT_W-1:0]   pmain;
    logic [PORT_W-1:0]   pext;

    assign ds    = req.disk_state;
    assign pmain = req.paging_port_main;
    assign pext  = req.paging_port_extra;

    always_comb
    begin
        offset = req.cpu_address[OFFSET_W-1:0];
        page   = PAGE_RAM0;
        case (req.cpu_address[15:14])
            WIN_ROM:
            begin
                page = PAGE_ROM_BASE;
                if (cfg.model != MODEL_48K && pmain[4])
                    page[0] = 1'b1;

                if (cfg.disk == DISK_SD)
                begin
                    if (!req.cpu_address[13])
                    begin
                        if (ds[8:6] == DS_SD_BOOT)
                        begin
                            page       = PAGE_SD_BOOT;
                            offset[13] = 1'b1;
                        end
                        else if (ds[8] || ds[7])
                            page[1:0] = 2'b11;
                    end
                    else if (ds[8] || ds[7])
                    begin
                        // bank 0x40|b: page is bank/2, offset bit 13 is bank bit 0
                        page       = {4'b0001, ds[5:1]};
                        offset[13] = ds[0];
                    end
                end
                else if (cfg.disk == DISK_SRAM)
                begin
                    if (ds[6])
                        page = {4'b0001, ds[4:0]};
                    else if (ds[7])
                        page[1:0] = 2'b11;
                end
                else if (cfg.model == MODEL_SERVICE)
                begin
                    if (pext[1])
                        page = PAGE_SERVICE;
                    else if (pmain[0])
                        page = PAGE_RAM0;
                end
                else if (cfg.disk == DISK_DOS && req.dos_rom_active)
                    page = PAGE_DOS;
            end
            WIN_FIX5: page = PAGE_FIX5;
            WIN_FIX2: page = PAGE_FIX2;
            WIN_TOP:
            begin
                case (cfg.model)
                    MODEL_1024K:   page = {3'b000, pmain[5], pmain[7:6], pmain[2:0]};
                    MODEL_SERVICE: page = {4'b0000, pext[5], 1'b0, pmain[2:0]};
                    MODEL_48K:     page = PAGE_RAM0;
                    default:       page = {6'b000000, pmain[2:0]};
                endcase
            end
            default: page = PAGE_RAM0;
        endcase
    end

    assign rsp.physical_address = {page, offset};

endmodule
`default_nettype wire

FILE: sv/banked_memory_page_mapper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// banked_memory_page_mapper_core
// Translates 16-bit CPU addresses into 23-bit physical addresses.
// ----------------------------------------------------------------------------
// Usage:
//   addr_in  : request channel (valid/ready). One transaction carries the CPU
//              address, both paging port values, the DOS ROM flag and the
//              disk interface state.
//   addr_out : result channel (valid/ready), one physical address per request.
//   cfg_*    : write-only port for machine model (index 0) and disk interface
//              (index 1). Write only while no transaction is in flight.
// Path: an accepted request goes into the input register, then through the
//   page logic into the result register, which raises addr_out.valid.
// Throughput: one transaction per cycle while addr_out.ready is high; the
//   limit is the single register stage pair, each stage refilling as it drains.
// Reset: both stage valid flags clear; model resets to 128K type, disk
//   interface to none.
// Stall: while addr_out.ready is low the result register holds, the input
//   register still fills once, then addr_in.ready drops until space frees.
// ----------------------------------------------------------------------------
module banked_memory_page_mapper_core
    import bmpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    bmpm_stream_if.sink                addr_in,
    bmpm_stream_if.source              addr_out
);

    cfg_t cfg;
    req_t req_reg;
    rsp_t rsp_next;
    rsp_t rsp_reg;
    logic req_valid_reg;
    logic rsp_valid_reg;
    logic rsp_load;
    logic req_load;

    bmpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bmpm_xlate u_xlate (
        .cfg (cfg),
        .req (req_reg),
        .rsp (rsp_next)
    );

    // Result stage takes a new value when empty or being drained
    assign rsp_load     = req_valid_reg && (!rsp_valid_reg || addr_out.ready);
    // Input stage refills when empty or when its item moves on
    assign addr_in.ready = !req_valid_reg || rsp_load;
    assign req_load     = addr_in.valid && addr_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (addr_in.ready)
                req_valid_reg <= addr_in.valid;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (addr_out.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_load)
            req_reg <= addr_in.data;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    assign addr_out.valid = rsp_valid_reg;
    assign addr_out.data  = rsp_reg;

`ifndef SYNTHESIS
    a_req_moves: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_valid_reg)
        else $error("result stage did not fill");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        req_load |=> req_valid_reg)
        else $error("input stage did not fill on accept");

    a_offset_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_reg.physical_address[12:0] == $past(req_reg.cpu_address[12:0]))
        else $error("low offset bits altered");

    a_fixed_page5: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load && req_reg.cpu_address[15:14] == WIN_FIX5
        |=> rsp_reg.physical_address[22:14] == PAGE_FIX5)
        else $error("window 4000-7FFF not on page 5");

    a_fixed_page2: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load && req_reg.cpu_address[15:14] == WIN_FIX2
        |=> rsp_reg.physical_address[22:14] == PAGE_FIX2)
        else $error("window 8000-BFFF not on page 2");
`endif

endmodule
`default_nettype wire
